>>> sv/nfe_pkg.sv
// Shared types, widths, register indexes and datapath operation codes for the
// neural field Euler step block. No dependencies.
package nfe_pkg;

	localparam int VALUE_W = 24;
	localparam int POS_W   = 10;
	localparam int MAX_POS = 1024;
	localparam int SIZE_W  = 11;
	localparam int GAIN_W  = 16;
	localparam int SUM_W   = 34;
	localparam int SQ_W    = 58;
	localparam int NORM_W  = 29;
	localparam int CENT_W  = 18;
	localparam int WSUM_W  = 22;
	localparam int DIV_W   = 34;
	localparam int DVS_W   = 12;
	localparam int DCNT_W  = 6;
	localparam int SQRT_STEPS = 29;
	localparam int SCNT_W  = 5;
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 24;

	localparam logic [IDX_W-1:0] REG_RESTING = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAIN    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE    = 2'd2;

	localparam logic signed [VALUE_W-1:0] RESTING_RST = -24'sd20480;
	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd6554;
	localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

	localparam logic signed [VALUE_W-1:0] ACTIVE_LEVEL = 24'sd409;
	localparam logic signed [SUM_W:0]     STABLE_LIMIT = 35'sd614;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE     = 5'd0;
	localparam op_t OP_CLR      = 5'd1;
	localparam op_t OP_READ     = 5'd2;
	localparam op_t OP_DIFF     = 5'd3;
	localparam op_t OP_MUL      = 5'd4;
	localparam op_t OP_UPD      = 5'd5;
	localparam op_t OP_ACC      = 5'd6;
	localparam op_t OP_SQ       = 5'd7;
	localparam op_t OP_WDIV_GO  = 5'd8;
	localparam op_t OP_WDIV_END = 5'd9;
	localparam op_t OP_AVG_GO   = 5'd10;
	localparam op_t OP_AVG_END  = 5'd11;
	localparam op_t OP_SQRT_GO  = 5'd12;
	localparam op_t OP_SQRT_END = 5'd13;
	localparam op_t OP_CEN_GO   = 5'd14;
	localparam op_t OP_CEN_END  = 5'd15;
	localparam op_t OP_LOAD     = 5'd16;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic clr_last;
		logic last;
		logic need_wdiv;
		logic found;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage

>>> sv/nfe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses widths from nfe_pkg.
module nfe_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nfe_pkg::DIV_W-1:0]    dividend,
	input  logic [nfe_pkg::DVS_W-1:0]    divisor,
	output logic [nfe_pkg::DIV_W-1:0]    quotient,
	output logic [nfe_pkg::DVS_W-1:0]    remainder,
	output logic                         done
);

	logic [nfe_pkg::DIV_W-1:0]  quo_q;
	logic [nfe_pkg::DVS_W-1:0]  rem_q;
	logic [nfe_pkg::DVS_W-1:0]  dvs_q;
	logic [nfe_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [nfe_pkg::DVS_W:0]    shifted;
	logic                       fits;

	assign shifted = {rem_q, quo_q[nfe_pkg::DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nfe_pkg::DCNT_W'(nfe_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == nfe_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[nfe_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? nfe_pkg::DVS_W'(shifted - {1'b0, dvs_q})
			              : nfe_pkg::DVS_W'(shifted);
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> sv/nfe_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Uses widths from nfe_pkg.
module nfe_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nfe_pkg::SQ_W-1:0]    value,
	output logic [nfe_pkg::NORM_W-1:0]  root,
	output logic                        done
);

	logic [nfe_pkg::SQ_W-1:0]   val_q;
	logic [nfe_pkg::NORM_W+1:0] rem_q;
	logic [nfe_pkg::NORM_W-1:0] root_q;
	logic [nfe_pkg::SCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [nfe_pkg::NORM_W+3:0] pulled;
	logic [nfe_pkg::NORM_W+3:0] trial;
	logic                       fits;

	assign pulled = {rem_q, val_q[nfe_pkg::SQ_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = pulled >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nfe_pkg::SCNT_W'(nfe_pkg::SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == nfe_pkg::SCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[nfe_pkg::SQ_W-3:0], 2'b00};
			root_q <= {root_q[nfe_pkg::NORM_W-2:0], fits};
			rem_q  <= fits ? (nfe_pkg::NORM_W+2)'(pulled - trial)
			               : (nfe_pkg::NORM_W+2)'(pulled);
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

>>> sv/nfe_datapath.sv
// Datapath: configuration registers, activation memory, Euler update,
// sweep statistics, output register. Depends on nfe_pkg, nfe_div, nfe_isqrt.
module nfe_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [nfe_pkg::IDX_W-1:0]           cfg_index,
	input  logic [nfe_pkg::CFG_W-1:0]           cfg_data,
	input  logic signed [nfe_pkg::VALUE_W-1:0]  external_input,
	input  nfe_pkg::cmd_t                       cmd,
	output nfe_pkg::status_t                    status,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [nfe_pkg::VALUE_W-1:0]  activation,
	output logic [nfe_pkg::POS_W-1:0]           position,
	output logic                                sweep_end,
	output logic                                centroid_found,
	output logic [nfe_pkg::CENT_W-1:0]          centroid,
	output logic                                stable
);

	localparam int VW = nfe_pkg::VALUE_W;
	localparam int SW = nfe_pkg::SUM_W;
	localparam int GAIN_PAD = nfe_pkg::GAIN_W + 2;

	// configuration
	logic signed [VW-1:0]              resting_q;
	logic [nfe_pkg::GAIN_W-1:0]        gain_q;
	logic [nfe_pkg::SIZE_W-1:0]        size_cfg_q;
	logic [nfe_pkg::SIZE_W-1:0]        size_eff;
	logic                              restart;

	// memory and item pipeline
	logic signed [VW-1:0]              mem [nfe_pkg::MAX_POS];
	logic signed [VW-1:0]              rdata_q;
	logic signed [VW-1:0]              in_q;
	logic signed [VW+1:0]              d_q;
	logic signed [VW+GAIN_PAD:0]       prod_q;
	logic signed [VW+3:0]              n_raw;
	logic signed [VW-1:0]              n_sat;
	logic signed [VW-1:0]              n_q;
	logic [2*VW-1:0]                   sq_q;
	logic [nfe_pkg::POS_W-1:0]         clr_q;

	// sweep state
	logic [nfe_pkg::POS_W-1:0]         pos_q;
	logic signed [SW-1:0]              sum_q;
	logic [nfe_pkg::SQ_W-1:0]          sqsum_q;
	logic [nfe_pkg::SIZE_W-1:0]        cnt_q;
	logic [nfe_pkg::WSUM_W-1:0]        wp_q;
	logic [nfe_pkg::WSUM_W-1:0]        ww_q;
	logic                              first_q;
	logic signed [SW-1:0]              prev_sum_q;
	logic signed [SW-1:0]              prev_avg_q;
	logic [nfe_pkg::NORM_W-1:0]        prev_norm_q;
	logic signed [SW-1:0]              avg_q;
	logic [nfe_pkg::NORM_W-1:0]        norm_q;
	logic [nfe_pkg::CENT_W-1:0]        cen_q;
	logic                              out_valid_q;

	// decoded values
	logic                              active;
	logic                              pos_lt_size;
	logic                              last;
	logic                              wrap_mode;
	logic [nfe_pkg::DVS_W-1:0]         wx;
	logic [nfe_pkg::DVS_W-1:0]         two_size;
	logic [nfe_pkg::DVS_W-1:0]         wterm;
	logic [SW-1:0]                     sum_mag;
	logic [nfe_pkg::WSUM_W:0]          cen_base;
	logic [nfe_pkg::CENT_W:0]          cen_lim;
	logic [nfe_pkg::DIV_W-1:0]         cen_q_full;
	logic signed [SW:0]                d_sum;
	logic signed [SW:0]                d_avg;
	logic signed [SW:0]                d_norm;
	logic                              is_stable;

	// shared divider, square-root unit
	logic                              div_start;
	logic [nfe_pkg::DIV_W-1:0]         div_dividend;
	logic [nfe_pkg::DVS_W-1:0]         div_divisor;
	logic [nfe_pkg::DIV_W-1:0]         div_quo;
	logic [nfe_pkg::DVS_W-1:0]         div_rem;
	logic                              div_done;
	logic [nfe_pkg::NORM_W-1:0]        sqrt_root;
	logic                              sqrt_done;

	assign restart = cfg_write && (cfg_index == nfe_pkg::REG_RESTING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resting_q  <= nfe_pkg::RESTING_RST;
			gain_q     <= nfe_pkg::GAIN_RST;
			size_cfg_q <= nfe_pkg::SIZE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nfe_pkg::REG_RESTING: resting_q  <= cfg_data;
				nfe_pkg::REG_GAIN:    gain_q     <= cfg_data[nfe_pkg::GAIN_W-1:0];
				nfe_pkg::REG_SIZE:    size_cfg_q <= cfg_data[nfe_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_cfg_q < nfe_pkg::SIZE_W'(2))
			size_eff = nfe_pkg::SIZE_W'(2);
		else if (size_cfg_q > nfe_pkg::SIZE_W'(nfe_pkg::MAX_POS))
			size_eff = nfe_pkg::SIZE_W'(nfe_pkg::MAX_POS);
		else
			size_eff = size_cfg_q;
	end

	// memory: clearing pass writes the resting level, an item writes its result
	always_ff @(posedge clk) begin
		if (cmd.op == nfe_pkg::OP_CLR)
			mem[clr_q] <= resting_q;
		else if (cmd.op == nfe_pkg::OP_ACC)
			mem[pos_q] <= n_q;
		if (cmd.op == nfe_pkg::OP_READ)
			rdata_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (restart)
			clr_q <= '0;
		else if (cmd.op == nfe_pkg::OP_CLR)
			clr_q <= clr_q + 1'b1;
	end

	// Euler update: the upper product bits are the floor of the shift by 16
	assign n_raw = {{4{rdata_q[VW-1]}}, rdata_q}
	             + {{(4 - 3){prod_q[VW+GAIN_PAD]}}, prod_q[VW+GAIN_PAD:nfe_pkg::GAIN_W]};

	always_comb begin
		if (n_raw[VW+3:VW-1] == '0 || n_raw[VW+3:VW-1] == '1)
			n_sat = n_raw[VW-1:0];
		else if (n_raw[VW+3])
			n_sat = {1'b1, {(VW-1){1'b0}}};
		else
			n_sat = {1'b0, {(VW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (cmd.op == nfe_pkg::OP_READ)
			in_q <= external_input;
		if (cmd.op == nfe_pkg::OP_DIFF)
			d_q <= {{2{resting_q[VW-1]}}, resting_q} + {{2{in_q[VW-1]}}, in_q}
			     - {{2{rdata_q[VW-1]}}, rdata_q};
		if (cmd.op == nfe_pkg::OP_MUL)
			prod_q <= $signed({1'b0, gain_q}) * d_q;
		if (cmd.op == nfe_pkg::OP_UPD)
			n_q <= n_sat;
		if (cmd.op == nfe_pkg::OP_ACC)
			sq_q <= (2*VW)'(n_q * n_q);
	end

	assign active      = n_q > nfe_pkg::ACTIVE_LEVEL;
	assign pos_lt_size = {1'b0, pos_q} < size_eff;
	assign last        = {1'b0, pos_q} >= (size_eff - 1'b1);
	assign wrap_mode   = first_q || active;
	assign two_size    = {size_eff, 1'b0};
	assign wx          = {1'b0, pos_q, 1'b0} + {1'b0, size_eff};
	assign wterm       = (wx >= two_size) ? (wx - two_size) : wx;
	assign sum_mag     = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign cen_base    = (nfe_pkg::WSUM_W+1)'(size_eff * cnt_q) + {1'b0, ww_q};
	assign cen_lim     = {size_eff, 8'd0};
	assign cen_q_full  = (wrap_mode && div_quo >= nfe_pkg::DIV_W'(cen_lim))
	                   ? (div_quo - nfe_pkg::DIV_W'(cen_lim)) : div_quo;

	// divider operands
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (cmd.op)
			nfe_pkg::OP_WDIV_GO: begin
				div_start    = 1'b1;
				div_dividend = nfe_pkg::DIV_W'(wx);
				div_divisor  = two_size;
			end
			nfe_pkg::OP_AVG_GO: begin
				div_start    = 1'b1;
				div_dividend = sum_mag;
				div_divisor  = nfe_pkg::DVS_W'(size_eff);
			end
			nfe_pkg::OP_CEN_GO: begin
				div_start    = 1'b1;
				div_dividend = wrap_mode ? nfe_pkg::DIV_W'({cen_base, 7'd0})
				                         : nfe_pkg::DIV_W'({wp_q, 8'd0});
				div_divisor  = nfe_pkg::DVS_W'(cnt_q);
			end
			default: ;
		endcase
	end

	nfe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	nfe_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == nfe_pkg::OP_SQRT_GO),
		.value  (sqsum_q),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == nfe_pkg::OP_AVG_END)
			avg_q <= sum_q[SW-1] ? -$signed(div_quo) : $signed(div_quo);
		if (cmd.op == nfe_pkg::OP_SQRT_END)
			norm_q <= sqrt_root;
		if (cmd.op == nfe_pkg::OP_CEN_END)
			cen_q <= nfe_pkg::CENT_W'(cen_q_full);
	end

	assign d_sum  = {sum_q[SW-1], sum_q} - {prev_sum_q[SW-1], prev_sum_q};
	assign d_avg  = {avg_q[SW-1], avg_q} - {prev_avg_q[SW-1], prev_avg_q};
	assign d_norm = $signed((SW+1)'(norm_q)) - $signed((SW+1)'(prev_norm_q));
	assign is_stable = (d_sum  <= nfe_pkg::STABLE_LIMIT) && (d_sum  >= -nfe_pkg::STABLE_LIMIT)
	                && (d_avg  <= nfe_pkg::STABLE_LIMIT) && (d_avg  >= -nfe_pkg::STABLE_LIMIT)
	                && (d_norm <= nfe_pkg::STABLE_LIMIT) && (d_norm >= -nfe_pkg::STABLE_LIMIT);

	// sweep statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			cnt_q       <= '0;
			wp_q        <= '0;
			ww_q        <= '0;
			first_q     <= 1'b0;
			prev_sum_q  <= '0;
			prev_avg_q  <= '0;
			prev_norm_q <= '0;
		end else if (restart) begin
			pos_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			cnt_q   <= '0;
			wp_q    <= '0;
			ww_q    <= '0;
			first_q <= 1'b0;
		end else begin
			case (cmd.op)
				nfe_pkg::OP_ACC: begin
					sum_q <= sum_q + {{(SW-VW){n_q[VW-1]}}, n_q};
					if (active) begin
						cnt_q <= cnt_q + 1'b1;
						wp_q  <= wp_q + nfe_pkg::WSUM_W'(pos_q);
						if (pos_q == '0)
							first_q <= 1'b1;
						// a position past the size needs a true remainder
						if (pos_lt_size)
							ww_q <= ww_q + nfe_pkg::WSUM_W'(wterm);
					end
				end
				nfe_pkg::OP_SQ:
					sqsum_q <= sqsum_q + nfe_pkg::SQ_W'(sq_q);
				nfe_pkg::OP_WDIV_END:
					ww_q <= ww_q + nfe_pkg::WSUM_W'(div_rem);
				nfe_pkg::OP_LOAD: begin
					if (last) begin
						prev_sum_q  <= sum_q;
						prev_avg_q  <= avg_q;
						prev_norm_q <= norm_q;
						pos_q   <= '0;
						sum_q   <= '0;
						sqsum_q <= '0;
						cnt_q   <= '0;
						wp_q    <= '0;
						ww_q    <= '0;
						first_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == nfe_pkg::OP_LOAD)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == nfe_pkg::OP_LOAD) begin
			activation     <= n_q;
			position       <= pos_q;
			sweep_end      <= last;
			centroid_found <= last && (cnt_q != '0);
			centroid       <= (last && (cnt_q != '0)) ? cen_q : '0;
			stable         <= last && is_stable;
		end
	end

	assign out_valid = out_valid_q;

	assign status.restart   = restart;
	assign status.clr_last  = clr_q == '1;
	assign status.last      = last;
	assign status.need_wdiv = active && !pos_lt_size;
	assign status.found     = cnt_q != '0;
	assign status.div_done  = div_done;
	assign status.sqrt_done = sqrt_done;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

>>> sv/nfe_ctrl.sv
// Controller: sequences the clearing pass, one item's update and the
// end-of-sweep statistics. Depends on nfe_pkg.
module nfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  nfe_pkg::status_t  status,
	output nfe_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIFF  = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_UPD   = 4'd4;
	localparam logic [3:0] S_ACC   = 4'd5;
	localparam logic [3:0] S_SQ    = 4'd6;
	localparam logic [3:0] S_WDIV  = 4'd7;
	localparam logic [3:0] S_WWAIT = 4'd8;
	localparam logic [3:0] S_AVG   = 4'd9;
	localparam logic [3:0] S_AVGW  = 4'd10;
	localparam logic [3:0] S_SQRT  = 4'd11;
	localparam logic [3:0] S_SQRTW = 4'd12;
	localparam logic [3:0] S_CEN   = 4'd13;
	localparam logic [3:0] S_CENW  = 4'd14;
	localparam logic [3:0] S_LOAD  = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = nfe_pkg::OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = nfe_pkg::OP_CLR;
				if (status.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = nfe_pkg::OP_READ;
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.op  = nfe_pkg::OP_DIFF;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op  = nfe_pkg::OP_MUL;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.op  = nfe_pkg::OP_UPD;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = nfe_pkg::OP_ACC;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = nfe_pkg::OP_SQ;
				if (status.need_wdiv)
					state_d = S_WDIV;
				else if (status.last)
					state_d = S_AVG;
				else
					state_d = S_LOAD;
			end
			S_WDIV: begin
				cmd.op  = nfe_pkg::OP_WDIV_GO;
				state_d = S_WWAIT;
			end
			S_WWAIT: begin
				if (status.div_done) begin
					cmd.op  = nfe_pkg::OP_WDIV_END;
					state_d = S_AVG;
				end
			end
			S_AVG: begin
				cmd.op  = nfe_pkg::OP_AVG_GO;
				state_d = S_AVGW;
			end
			S_AVGW: begin
				if (status.div_done) begin
					cmd.op  = nfe_pkg::OP_AVG_END;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op  = nfe_pkg::OP_SQRT_GO;
				state_d = S_SQRTW;
			end
			S_SQRTW: begin
				if (status.sqrt_done) begin
					cmd.op  = nfe_pkg::OP_SQRT_END;
					state_d = status.found ? S_CEN : S_LOAD;
				end
			end
			S_CEN: begin
				cmd.op  = nfe_pkg::OP_CEN_GO;
				state_d = S_CENW;
			end
			S_CENW: begin
				if (status.div_done) begin
					cmd.op  = nfe_pkg::OP_CEN_END;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.op  = nfe_pkg::OP_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		if (status.restart)
			state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == S_WWAIT || state_q == S_AVGW || state_q == S_CENW))
		else $error("divider finished outside a wait state");

	a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.sqrt_done |-> state_q == S_SQRTW)
		else $error("square root finished outside its wait state");

	a_clear_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && status.clr_last && !status.restart) |=> state_q == S_IDLE)
		else $error("clearing pass did not end in idle");

	a_wdiv_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ && status.need_wdiv) |-> status.last)
		else $error("remainder division on a position that does not end the sweep");
`endif

endmodule

>>> sv/neural_field_euler_step_top.sv
// Top level of the neural field Euler step block: controller plus datapath.
// Depends on nfe_pkg, nfe_ctrl, nfe_datapath.
//
// Use: each input word on in_valid/in_stall carries external_input for the
// next field position of the sweep (0 .. field_size-1). The block returns one
// word per input on out_valid/out_stall with the updated activation and its
// position; the word of the last position also carries sweep_end, the
// centroid and the stable flag.
// Timing: an ordinary position passes through memory read at acceptance,
// difference, gain multiply, saturate, accumulate, square-sum and load, and
// the next word is taken only after its load. The last position adds the
// end-of-sweep sequence: an average division on the shared serial divider,
// the serial square root and, if an active position was found, a centroid
// division; an active position past a shrunken field size adds one more
// divider run first. One item is in work at once.
// Reset, and each write of resting_level, starts a clearing pass that loads
// every activation with the resting level; no input is taken during it. A
// stalled output word holds; the next item is accepted and worked on, and
// waits before its load until the output register frees.
module neural_field_euler_step_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [nfe_pkg::IDX_W-1:0]           cfg_index,
	input  logic [nfe_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [nfe_pkg::VALUE_W-1:0]  external_input,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [nfe_pkg::VALUE_W-1:0]  activation,
	output logic [nfe_pkg::POS_W-1:0]           position,
	output logic                                sweep_end,
	output logic                                centroid_found,
	output logic [nfe_pkg::CENT_W-1:0]          centroid,
	output logic                                stable
);

	nfe_pkg::cmd_t    cmd;
	nfe_pkg::status_t status;

	nfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	nfe_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.external_input (external_input),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.activation     (activation),
		.position       (position),
		.sweep_end      (sweep_end),
		.centroid_found (centroid_found),
		.centroid       (centroid),
		.stable         (stable)
	);

endmodule
